### sv/button_macro_trigger_engine_top_defines.svh
// Assertion macros for the button macro trigger engine.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BUTTON_MACRO_TRIGGER_ENGINE_TOP_DEFINES_SVH
`define BUTTON_MACRO_TRIGGER_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BMTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/bmte_pkg.sv
// Shared types and constants of the button macro trigger engine.
// Used by button_macro_trigger_engine_top; no dependencies.
package bmte_pkg;

  localparam int MACRO_SLOTS = 16;
  localparam int BUTTON_BITS = 8;
  localparam int SLOT_W      = $clog2(MACRO_SLOTS);
  localparam int PTR_W       = $clog2(MACRO_SLOTS + 1);

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_ONCE   = 2'd0,
    MODE_KEEP   = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [BUTTON_BITS-1:0] mask;
    mode_e                  mode;
    logic [15:0]            interval;
    logic                   cancel;
    logic                   min;
    logic                   mout;
    logic                   trig_now;
    logic                   trig_before;
    logic                   toggle_on;
    logic [31:0]            last_fire;
  } entry_t;

endpackage

### sv/button_macro_trigger_engine_top.sv
// Throughput: one write or disabled tick per cycle; a report or enabled tick holds the input
// stalled until its walk and flush end. The walk reads one slot of the entry memory per cycle
// unless an output stall holds it, and writes each slot back from its registered read. A fire
// waits for the next fire of the walk or the walk's end so that the last one is marked.
// Reset clears the slot active bits, the tick counter and the output valid, and sets enable.
// Uses bmte_pkg, bmte_ram and the assertion macro header.
`include "button_macro_trigger_engine_top_defines.svh"

module button_macro_trigger_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [7:0]  trigger_mask_i,
  input  logic [1:0]  action_mode_i,
  input  logic [15:0] repeat_interval_i,
  input  logic        cancel_input_i,
  input  logic        mouse_input_i,
  input  logic        mouse_output_i,
  input  logic [7:0]  buttons_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [3:0]  macro_index_o,
  output logic        cancel_report_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int EntryW = $bits(bmte_pkg::entry_t);

  bmte_pkg::state_e state_q, state_d;
  bmte_pkg::kind_e  kind_q, kind_d;

  logic [bmte_pkg::MACRO_SLOTS-1:0] active_q, active_d;
  logic [31:0]                      tick_q, tick_d;
  logic                             enabled_q;
  logic [bmte_pkg::BUTTON_BITS-1:0] btn_q, btn_d;
  logic                             cancel_q, cancel_d;
  logic [bmte_pkg::PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic                             ev_v_q, ev_v_d;
  logic [bmte_pkg::SLOT_W-1:0]      ev_slot_q, ev_slot_d;
  logic                             pend_v_q, pend_v_d;
  logic [bmte_pkg::SLOT_W-1:0]      pend_idx_q, pend_idx_d;

  logic       out_valid_q;
  logic       out_kind_q, out_kind_d;
  logic [3:0] out_idx_q, out_idx_d;
  logic       out_cancel_q, out_cancel_d;
  logic       out_last_q, out_last_d;
  logic       push;

  logic                        ram_we, ram_re;
  logic [bmte_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [EntryW-1:0]           ram_wdata, ram_rdata;

  bmte_pkg::entry_t rd_e, mod_e, new_e;
  bmte_pkg::req_e   req;
  logic             in_acc, out_free, rd_done;
  logic             ev_active, fire, ev_emit, ev_go, due, rise, ton;

  bmte_ram #(
    .WIDTH (EntryW),
    .DEPTH (bmte_pkg::MACRO_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req         = bmte_pkg::req_e'(req_type_i);
  assign in_stall_o  = (state_q != bmte_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_done     = (rd_ptr_q == bmte_pkg::PTR_W'(bmte_pkg::MACRO_SLOTS));
  assign cfg_ready_o = 1'b1;

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign macro_index_o   = out_idx_q;
  assign cancel_report_o = out_cancel_q;
  assign last_of_run_o   = out_last_q;

  // Evaluation of the slot whose memory word is on the read port.
  always_comb begin
    rd_e      = bmte_pkg::entry_t'(ram_rdata);
    mod_e     = rd_e;
    ev_active = active_q[ev_slot_q];
    fire      = 1'b0;
    rise      = rd_e.trig_now && !rd_e.trig_before;
    due       = ((tick_q - rd_e.last_fire) >= {16'd0, rd_e.interval});
    ton       = rd_e.toggle_on ^ rise;
    if (kind_q == bmte_pkg::KIND_REPORT) begin
      if (rd_e.min) begin
        mod_e.trig_now = ((rd_e.mask & btn_q) == rd_e.mask);
      end
    end else begin
      case (rd_e.mode)
        bmte_pkg::MODE_ONCE: begin
          fire              = rise;
          mod_e.trig_before = rd_e.trig_now;
        end
        bmte_pkg::MODE_KEEP: begin
          if (rd_e.trig_now && due) begin
            fire            = 1'b1;
            mod_e.last_fire = tick_q;
          end
        end
        bmte_pkg::MODE_TOGGLE: begin
          mod_e.toggle_on = ton;
          if (ton && due) begin
            fire            = 1'b1;
            mod_e.last_fire = tick_q;
          end
          mod_e.trig_before = rd_e.trig_now;
        end
        default: begin
          fire = 1'b0;
        end
      endcase
    end
    ev_emit = ev_v_q && ev_active && (kind_q == bmte_pkg::KIND_TICK) && fire && rd_e.mout;
    ev_go   = !(ev_emit && pend_v_q) || out_free;
  end

  always_comb begin
    new_e             = '0;
    new_e.mask        = trigger_mask_i;
    new_e.mode        = bmte_pkg::mode_e'(action_mode_i);
    new_e.interval    = repeat_interval_i;
    new_e.cancel      = cancel_input_i;
    new_e.min         = mouse_input_i;
    new_e.mout        = mouse_output_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmte_pkg::ST_IDLE: begin
        if (in_acc && (req == bmte_pkg::REQ_REPORT)) begin
          state_d = bmte_pkg::ST_WALK;
        end else if (in_acc && (req == bmte_pkg::REQ_TICK) && enabled_q) begin
          state_d = bmte_pkg::ST_WALK;
        end
      end
      bmte_pkg::ST_WALK: begin
        if (rd_done && (!ev_v_q || ev_go)) begin
          state_d = bmte_pkg::ST_FLUSH;
        end
      end
      bmte_pkg::ST_FLUSH: begin
        if (out_free || (kind_q == bmte_pkg::KIND_TICK && !pend_v_q)) begin
          state_d = bmte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmte_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    kind_d       = kind_q;
    active_d     = active_q;
    tick_d       = tick_q;
    btn_d        = btn_q;
    cancel_d     = cancel_q;
    rd_ptr_d     = rd_ptr_q;
    ev_v_d       = ev_v_q;
    ev_slot_d    = ev_slot_q;
    pend_v_d     = pend_v_q;
    pend_idx_d   = pend_idx_q;
    push         = 1'b0;
    out_kind_d   = out_kind_q;
    out_idx_d    = out_idx_q;
    out_cancel_d = out_cancel_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = ev_slot_q;
    ram_wdata    = EntryW'(mod_e);
    ram_re       = 1'b0;
    ram_raddr    = rd_ptr_q[bmte_pkg::SLOT_W-1:0];
    unique case (state_q)
      bmte_pkg::ST_IDLE: begin
        rd_ptr_d = '0;
        ev_v_d   = 1'b0;
        pend_v_d = 1'b0;
        cancel_d = 1'b0;
        if (in_acc) begin
          unique case (req)
            bmte_pkg::REQ_WRITE: begin
              if (32'(entry_index_i) < bmte_pkg::MACRO_SLOTS) begin
                ram_we    = 1'b1;
                ram_waddr = entry_index_i[bmte_pkg::SLOT_W-1:0];
                ram_wdata = EntryW'(new_e);
                active_d[entry_index_i[bmte_pkg::SLOT_W-1:0]] = entry_valid_i;
              end
            end
            bmte_pkg::REQ_REPORT: begin
              kind_d = bmte_pkg::KIND_REPORT;
              btn_d  = buttons_i;
            end
            bmte_pkg::REQ_TICK: begin
              kind_d = bmte_pkg::KIND_TICK;
              tick_d = tick_q + 32'd1;
            end
            default: begin
              kind_d = kind_q;
            end
          endcase
        end
      end
      bmte_pkg::ST_WALK: begin
        if (ev_v_q && ev_go) begin
          ram_we = ev_active;
          if (ev_active && (kind_q == bmte_pkg::KIND_REPORT) && rd_e.min) begin
            cancel_d = cancel_q || (mod_e.trig_now && rd_e.cancel);
          end
          if (ev_emit) begin
            if (pend_v_q) begin
              push         = 1'b1;
              out_kind_d   = bmte_pkg::KIND_TICK;
              out_idx_d    = 4'(pend_idx_q);
              out_cancel_d = 1'b0;
              out_last_d   = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = ev_slot_q;
          end
        end
        if (!ev_v_q || ev_go) begin
          if (!rd_done) begin
            ram_re    = 1'b1;
            ev_v_d    = 1'b1;
            ev_slot_d = rd_ptr_q[bmte_pkg::SLOT_W-1:0];
            rd_ptr_d  = rd_ptr_q + 1'b1;
          end else begin
            ev_v_d = 1'b0;
          end
        end
      end
      bmte_pkg::ST_FLUSH: begin
        if (out_free) begin
          if (kind_q == bmte_pkg::KIND_REPORT) begin
            push         = 1'b1;
            out_kind_d   = bmte_pkg::KIND_REPORT;
            out_idx_d    = 4'd0;
            out_cancel_d = cancel_q;
            out_last_d   = 1'b1;
          end else if (pend_v_q) begin
            push         = 1'b1;
            out_kind_d   = bmte_pkg::KIND_TICK;
            out_idx_d    = 4'(pend_idx_q);
            out_cancel_d = 1'b0;
            out_last_d   = 1'b1;
            pend_v_d     = 1'b0;
          end
        end
      end
      default: begin
        ev_v_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmte_pkg::ST_IDLE;
      kind_q      <= bmte_pkg::KIND_REPORT;
      active_q    <= '0;
      tick_q      <= '0;
      enabled_q   <= 1'b1;
      rd_ptr_q    <= '0;
      ev_v_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      cancel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      active_q <= active_d;
      tick_q   <= tick_d;
      rd_ptr_q <= rd_ptr_d;
      ev_v_q   <= ev_v_d;
      pend_v_q <= pend_v_d;
      cancel_q <= cancel_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enabled_q <= cfg_data_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    btn_q        <= btn_d;
    ev_slot_q    <= ev_slot_d;
    pend_idx_q   <= pend_idx_d;
    out_kind_q   <= out_kind_d;
    out_idx_q    <= out_idx_d;
    out_cancel_q <= out_cancel_d;
    out_last_q   <= out_last_d;
  end

  `BMTE_ASSERT_IMP(a_ram_no_collision, ram_we && ram_re, ram_waddr != ram_raddr)
  `BMTE_ASSERT_IMP(a_push_needs_room, push, out_free)
  `BMTE_ASSERT_NEXT(a_report_starts_walk, in_acc && (req == bmte_pkg::REQ_REPORT), state_q == bmte_pkg::ST_WALK)
  `BMTE_ASSERT_IMP(a_pending_only_on_tick, pend_v_q, kind_q == bmte_pkg::KIND_TICK)

endmodule

### sv/bmte_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; the read data holds while the read enable is low.
module bmte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
